/* rtl/lipl_pkg.sv */
`timescale 1ns / 1ps
package lipl_pkg;

   // Listing geometry.
   localparam int MAX_DEPTH = 256;
   localparam int LEN_BITS  = 16;
   localparam int DEPTH_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CHAR_W    = 8;
   localparam int OUT_W     = 16;
   localparam int EXT_W     = LEN_BITS + OUT_W;

   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
   localparam logic [OUT_W-1:0]    OUT_MAX = '1;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_DOT     = 8'd46;

   // Output queue geometry.
   localparam int OQ_DEPTH = 3;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 2;

   // A closed line, handed from the scanner to the close stage.
   typedef struct packed {
      logic                valid;
      logic                last_item;
      logic                is_file;
      logic [LEN_BITS-1:0] len;
      logic [DEPTH_W-1:0]  depth;
      logic                ovf;
   } close_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] longest;
      logic             overflow;
   } result_type;

endpackage

/* rtl/lipl_ram.sv */
`timescale 1ns / 1ps
module lipl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lipl_scan.sv */
`timescale 1ns / 1ps
module lipl_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [lipl_pkg::CHAR_W-1:0]   char_code,
   input  logic                          is_final,
   output lipl_pkg::close_req_type       close_req
);

   logic [lipl_pkg::DEPTH_W-1:0]  depth_ff, depth_in, depth_upd;
   logic [lipl_pkg::LEN_BITS-1:0] len_ff, len_in, len_upd;
   logic                          file_ff, file_in, file_upd;
   logic                          ovf_ff, ovf_in, ovf_upd;
   logic                          is_nl, is_tab, closing;

   always_comb begin
      depth_upd = depth_ff;
      len_upd   = len_ff;
      file_upd  = file_ff;
      ovf_upd   = ovf_ff;
      is_nl     = (char_code == lipl_pkg::CH_NEWLINE);
      is_tab    = (char_code == lipl_pkg::CH_TAB);

      if (is_tab) begin
         if ((lipl_pkg::DEPTH_W+1)'(depth_ff) + (lipl_pkg::DEPTH_W+1)'(1)
             < (lipl_pkg::DEPTH_W+1)'(lipl_pkg::MAX_DEPTH)) begin
            depth_upd = depth_ff + lipl_pkg::DEPTH_W'(1);
         end else begin
            ovf_upd = 1'b1;
         end
      end else if (!is_nl) begin
         if (char_code == lipl_pkg::CH_DOT) begin
            file_upd = 1'b1;
         end
         if (len_ff == lipl_pkg::LEN_MAX) begin
            ovf_upd = 1'b1;
         end else begin
            len_upd = len_ff + lipl_pkg::LEN_BITS'(1);
         end
      end

      closing = accept && (is_nl || is_final);

      close_req.valid     = closing;
      close_req.last_item = is_final;
      close_req.is_file   = file_upd;
      close_req.len       = len_upd;
      close_req.depth     = depth_upd;
      close_req.ovf       = ovf_upd;

      depth_in = depth_ff;
      len_in   = len_ff;
      file_in  = file_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (closing) begin
            depth_in = '0;
            len_in   = '0;
            file_in  = 1'b0;
         end else begin
            depth_in = depth_upd;
            len_in   = len_upd;
            file_in  = file_upd;
         end
         ovf_in = is_final ? 1'b0 : ovf_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         len_ff   <= '0;
         file_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         len_ff   <= len_in;
         file_ff  <= file_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

/* rtl/lipl_close.sv */
`timescale 1ns / 1ps
module lipl_close (
   input  logic                           clock,
   input  logic                           reset,
   input  lipl_pkg::close_req_type        close_req,
   output logic                           rd_en,
   output logic [lipl_pkg::DEPTH_W-1:0]   rd_addr,
   input  logic [lipl_pkg::LEN_BITS-1:0]  rd_data,
   output logic                           wr_en,
   output logic [lipl_pkg::DEPTH_W-1:0]   wr_addr,
   output logic [lipl_pkg::LEN_BITS-1:0]  wr_data,
   output logic                           res_valid,
   output lipl_pkg::result_type           res
);

   lipl_pkg::close_req_type         s1_ff;
   logic                            fwd_hit_ff, fwd_hit_in;
   logic [lipl_pkg::LEN_BITS-1:0]   fwd_data_ff;
   logic                            vbit_ff, vbit_in;
   logic [lipl_pkg::MAX_DEPTH-1:0]  valid_ff, valid_in;
   logic [lipl_pkg::LEN_BITS-1:0]   best_ff, best_in, new_best;
   logic                            ovs_ff, ovs_in;

   logic [lipl_pkg::LEN_BITS-1:0]   prefix, sat;
   logic [lipl_pkg::LEN_BITS:0]     sum;
   logic                            deepest, sum_used, ov_ev, ov_total, ending;
   logic [lipl_pkg::EXT_W-1:0]      best_ext;

   assign rd_en   = close_req.valid;
   assign rd_addr = close_req.depth;

   always_comb begin
      prefix = fwd_hit_ff ? fwd_data_ff : (vbit_ff ? rd_data : '0);
      sum = {1'b0, prefix} + {1'b0, s1_ff.len}
            + (lipl_pkg::LEN_BITS+1)'(!s1_ff.is_file);
      sat = sum[lipl_pkg::LEN_BITS] ? lipl_pkg::LEN_MAX : sum[lipl_pkg::LEN_BITS-1:0];

      deepest  = (s1_ff.depth == lipl_pkg::DEPTH_W'(lipl_pkg::MAX_DEPTH - 1));
      // A directory at the deepest level has no child slot and does no sum.
      sum_used = s1_ff.valid && (s1_ff.is_file || !deepest);
      ov_ev    = sum_used && sum[lipl_pkg::LEN_BITS];
      ending   = s1_ff.valid && s1_ff.last_item;

      new_best = (s1_ff.valid && s1_ff.is_file && sat > best_ff) ? sat : best_ff;

      wr_en   = s1_ff.valid && !s1_ff.is_file && !deepest && !s1_ff.last_item;
      wr_addr = s1_ff.depth + lipl_pkg::DEPTH_W'(1);
      wr_data = sat;

      ov_total = ovs_ff || ov_ev || s1_ff.ovf;
      best_ext = lipl_pkg::EXT_W'(new_best);
      res_valid = ending;
      if (best_ext > lipl_pkg::EXT_W'(lipl_pkg::OUT_MAX)) begin
         res.longest  = lipl_pkg::OUT_MAX;
         res.overflow = 1'b1;
      end else begin
         res.longest  = lipl_pkg::OUT_W'(best_ext);
         res.overflow = ov_total;
      end

      // A read that meets this cycle's write to the same entry takes the new value.
      fwd_hit_in = close_req.valid && wr_en && (close_req.depth == wr_addr);
      vbit_in    = valid_ff[close_req.depth] && !ending;

      valid_in = valid_ff;
      if (ending) begin
         valid_in = '0;
         best_in  = '0;
         ovs_in   = 1'b0;
      end else begin
         if (wr_en) begin
            valid_in[wr_addr] = 1'b1;
         end
         best_in = new_best;
         ovs_in  = ovs_ff || ov_ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff      <= '0;
         fwd_hit_ff <= 1'b0;
         vbit_ff    <= 1'b0;
         valid_ff   <= '0;
         best_ff    <= '0;
         ovs_ff     <= 1'b0;
      end else begin
         s1_ff      <= close_req;
         fwd_hit_ff <= fwd_hit_in;
         vbit_ff    <= vbit_in;
         valid_ff   <= valid_in;
         best_ff    <= best_in;
         ovs_ff     <= ovs_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wr_data;
   end

   a_no_root_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_addr != '0)
      else $error("prefix write to the root entry");

   a_clear_on_end: assert property (@(posedge clock) disable iff (reset)
      (s1_ff.valid && s1_ff.last_item) |=> (valid_ff == '0 && best_ff == '0 && !ovs_ff))
      else $error("state not cleared after the final line");

   a_fwd_has_item: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_ff.valid)
      else $error("forward hit without a closing line");

   a_fwd_match: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> $past(wr_en) && s1_ff.depth == $past(wr_addr))
      else $error("forward hit does not match the previous write");

endmodule

/* rtl/lipl_outq.sv */
`timescale 1ns / 1ps
module lipl_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lipl_pkg::result_type  push_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lipl_pkg::result_type  rsp_data,
   output logic                  near_full
);

   lipl_pkg::result_type           q_ff [lipl_pkg::OQ_DEPTH];
   logic [lipl_pkg::OQ_PTR_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [lipl_pkg::OQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                           pop;

   always_comb begin
      rsp_valid = (cnt_ff != '0);
      rsp_data  = q_ff[head_ff];
      pop       = rsp_valid && !rsp_stall;
      // A result still in the close stage will land here next cycle.
      near_full = ((lipl_pkg::OQ_CNT_W+1)'(cnt_ff) + (lipl_pkg::OQ_CNT_W+1)'(push))
                  >= (lipl_pkg::OQ_CNT_W+1)'(lipl_pkg::OQ_DEPTH);

      head_in = head_ff;
      tail_in = tail_ff;
      if (pop) begin
         head_in = (head_ff == lipl_pkg::OQ_PTR_W'(lipl_pkg::OQ_DEPTH - 1)) ?
                   '0 : head_ff + lipl_pkg::OQ_PTR_W'(1);
      end
      if (push) begin
         tail_in = (tail_ff == lipl_pkg::OQ_PTR_W'(lipl_pkg::OQ_DEPTH - 1)) ?
                   '0 : tail_ff + lipl_pkg::OQ_PTR_W'(1);
      end
      cnt_in = cnt_ff + lipl_pkg::OQ_CNT_W'(push) - lipl_pkg::OQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= push_data;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != lipl_pkg::OQ_CNT_W'(lipl_pkg::OQ_DEPTH) || pop))
      else $error("result pushed into a full queue");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= lipl_pkg::OQ_CNT_W'(lipl_pkg::OQ_DEPTH))
      else $error("queue count out of range");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with unequal pointers");

endmodule

/* rtl/longest_indented_path_length_unit.sv */
`timescale 1ns / 1ps
// Longest file path in an indented directory listing. The listing streams in one byte per
// transfer on the req_ channel; a newline ends a line, each tab deepens the line, and a dot
// marks it as a file. The transfer flagged req_is_final closes the last line and yields
// one rsp_ transfer with the longest path length and the sticky overflow flag; every
// other transfer yields none. The unit takes one byte every cycle while req_stall is low.
// The per-depth prefix lengths sit in a 256-entry single-port-read memory that is read
// once per line end and written back in the next cycle, with forwarding when the next line
// end reads the entry just written, so back-to-back empty lines run at full rate. A
// three-entry result queue lets input flow on while results wait; req_stall rises only
// when that queue is about to fill because the result side is stalling. Per-entry valid
// bits make the prefix memory read as zero after reset and after each final transfer, so
// there is no clearing pass and the next listing may start in the following cycle.
module longest_indented_path_length_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lipl_pkg::CHAR_W-1:0]  req_char_code,
   input  logic                         req_is_final,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lipl_pkg::OUT_W-1:0]   rsp_longest,
   output logic                         rsp_overflow
);

   logic                            accept;
   lipl_pkg::close_req_type         close_req;
   logic                            rd_en, wr_en, res_valid, near_full;
   logic [lipl_pkg::DEPTH_W-1:0]    rd_addr, wr_addr;
   logic [lipl_pkg::LEN_BITS-1:0]   rd_data, wr_data;
   lipl_pkg::result_type            res, rsp_data;

   assign accept = req_valid && !req_stall;

   // Line scanner: tracks depth, name length and the file mark of the open line.
   lipl_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_char_code),
      .is_final  (req_is_final),
      .close_req (close_req)
   );

   // Prefix length per depth.
   lipl_ram #(
      .WIDTH (lipl_pkg::LEN_BITS),
      .DEPTH (lipl_pkg::MAX_DEPTH)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Line close: adds the prefix, updates the best length or writes the child prefix.
   lipl_close u_close (
      .clock     (clock),
      .reset     (reset),
      .close_req (close_req),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .res_valid (res_valid),
      .res       (res)
   );

   // Result queue toward the rsp_ side.
   lipl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .near_full (near_full)
   );

   assign req_stall    = near_full;
   assign rsp_longest  = rsp_data.longest;
   assign rsp_overflow = rsp_data.overflow;

endmodule

/* test/lipl_path_checker.sv */
`timescale 1ns / 1ps
module lipl_path_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic [lipl_pkg::CHAR_W-1:0]           req_char_code,
   input  logic                                  req_is_final,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [lipl_pkg::OUT_W-1:0]            rsp_longest,
   input  logic                                  rsp_overflow,
   output int                                    mismatches,
   output int                                    results_due
);

   // Prediction state for the listing in progress.
   logic [lipl_pkg::LEN_BITS-1:0] dir_prefix [lipl_pkg::MAX_DEPTH];
   int                            tab_level;
   logic [lipl_pkg::LEN_BITS-1:0] name_len;
   logic                          has_dot;
   logic [lipl_pkg::LEN_BITS-1:0] longest_so_far;
   logic                          sticky_ovf;

   lipl_pkg::result_type awaited_results [$];

   function automatic logic [lipl_pkg::LEN_BITS-1:0] clip_len(input longint unsigned sum);
      if (sum > lipl_pkg::LEN_MAX) begin
         sticky_ovf = 1'b1;
         return lipl_pkg::LEN_MAX;
      end
      return sum[lipl_pkg::LEN_BITS-1:0];
   endfunction

   task automatic clear_listing();
      foreach (dir_prefix[i]) dir_prefix[i] = '0;
      tab_level      = 0;
      name_len       = '0;
      has_dot        = 1'b0;
      longest_so_far = '0;
      sticky_ovf     = 1'b0;
   endtask

   task automatic close_current_line();
      logic [lipl_pkg::LEN_BITS-1:0] path_len;
      longint unsigned               base;
      base = dir_prefix[tab_level];
      if (has_dot) begin
         path_len = clip_len(base + name_len);
         if (path_len > longest_so_far) longest_so_far = path_len;
      end else if (tab_level + 1 < lipl_pkg::MAX_DEPTH) begin
         // A directory at the deepest level has no slot for its children.
         dir_prefix[tab_level + 1] = clip_len(base + name_len + 1);
      end
      tab_level = 0;
      name_len  = '0;
      has_dot   = 1'b0;
   endtask

   task automatic scan_char(input logic [lipl_pkg::CHAR_W-1:0] ch, input logic last);
      lipl_pkg::result_type outcome;
      if (ch == lipl_pkg::CH_NEWLINE) begin
         close_current_line();
      end else if (ch == lipl_pkg::CH_TAB) begin
         if (tab_level + 1 < lipl_pkg::MAX_DEPTH) tab_level++;
         else sticky_ovf = 1'b1;
      end else begin
         if (ch == lipl_pkg::CH_DOT) has_dot = 1'b1;
         name_len = clip_len(longint'(name_len) + 1);
      end
      if (last) begin
         // A closing newline already ended the line; anything else ends it here.
         if (ch != lipl_pkg::CH_NEWLINE) close_current_line();
         outcome.longest  = lipl_pkg::OUT_W'(longest_so_far);
         outcome.overflow = sticky_ovf;
         if (longest_so_far > lipl_pkg::OUT_MAX) begin
            outcome.longest  = lipl_pkg::OUT_MAX;
            outcome.overflow = 1'b1;
         end
         awaited_results = {awaited_results, outcome};
         clear_listing();
      end
   endtask

   task automatic check_result();
      lipl_pkg::result_type due;
      if (awaited_results.size() == 0) begin
         $error("rsp transfer with nothing awaited: longest %0d overflow %0b",
                rsp_longest, rsp_overflow);
         mismatches++;
      end else begin
         due = awaited_results.pop_front();
         if (rsp_longest !== due.longest) begin
            $error("longest: expected %0d, actual %0d", due.longest, rsp_longest);
            mismatches++;
         end
         if (rsp_overflow !== due.overflow) begin
            $error("overflow: expected %0b, actual %0b", due.overflow, rsp_overflow);
            mismatches++;
         end
      end
   endtask

   // Inputs change only at rising edges, so the middle of the cycle shows exactly what
   // the next rising edge will take. Results are checked before the input of the same
   // edge is scanned, so a result can never be matched against its own request.
   always @(negedge clock) begin
      if (reset) begin
         clear_listing();
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) scan_char(req_char_code, req_is_final);
      end
      results_due = awaited_results.size();
   end

endmodule

/* test/tb_longest_indented_path_length_unit.sv */
`timescale 1ns / 1ps
module tb_longest_indented_path_length_unit;

   logic                          clock         = 1'b0;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic [lipl_pkg::CHAR_W-1:0]   req_char_code = '0;
   logic                          req_is_final  = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall     = 1'b0;
   logic [lipl_pkg::OUT_W-1:0]    rsp_longest;
   logic                          rsp_overflow;

   int mismatches;
   int results_due;

   // When set, neither side idles: used for one stretch of the random part, so that
   // full-rate streaming gets exercised as well.
   bit steady = 1'b0;

   // Bytes of the listing being assembled, and counts for the random part.
   logic [lipl_pkg::CHAR_W-1:0] listing_bytes [$];
   int                          bytes_sent    = 0;
   int                          listings_sent = 0;

   always #5 clock = ~clock;

   longest_indented_path_length_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_is_final  (req_is_final),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_longest   (rsp_longest),
      .rsp_overflow  (rsp_overflow)
   );

   // The checker watches both channels, predicts every result and counts mismatches.
   lipl_path_checker path_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_is_final  (req_is_final),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_longest   (rsp_longest),
      .rsp_overflow  (rsp_overflow),
      .mismatches    (mismatches),
      .results_due   (results_due)
   );

   // Idle cycles before a transfer. At least a quarter of the draws are zero so that runs of
   // back-to-back transfers show up even outside the steady stretch.
   function automatic int unsigned pick_gap();
      if (steady || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 15);
   endfunction

   // Any byte that is neither a tab, a newline nor a dot, so it only adds name length.
   function automatic logic [lipl_pkg::CHAR_W-1:0] plain_char();
      logic [lipl_pkg::CHAR_W-1:0] c;
      do c = lipl_pkg::CHAR_W'($urandom_range(0, 255));
      while (c == lipl_pkg::CH_TAB || c == lipl_pkg::CH_NEWLINE || c == lipl_pkg::CH_DOT);
      return c;
   endfunction

   // Adds one byte at the end of the listing being assembled.
   task automatic append_byte(input logic [lipl_pkg::CHAR_W-1:0] b);
      listing_bytes = {listing_bytes, b};
   endtask

   // Appends a name of the given length; a file name gets one dot at a random place.
   task automatic add_name(input int n, input bit want_dot);
      int dot_at;
      dot_at = want_dot ? $urandom_range(0, n - 1) : -1;
      for (int k = 0; k < n; k++)
         append_byte((k == dot_at) ? lipl_pkg::CH_DOT : plain_char());
   endtask

   task automatic add_tabs(input int n);
      repeat (n) append_byte(lipl_pkg::CH_TAB);
   endtask

   // Presents one byte after a random gap and returns at the edge that takes it.
   // Stall is looked at mid-cycle, where it is stable up to the next rising edge.
   task automatic push_char(input logic [lipl_pkg::CHAR_W-1:0] ch, input logic last);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= ch;
      req_is_final  <= last;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   // Streams the assembled listing, flagging its last byte as final, and clears it.
   task automatic send_listing();
      int n;
      n = listing_bytes.size();
      for (int i = 0; i < n; i++) push_char(listing_bytes[i], i == n - 1);
      bytes_sent += n;
      listings_sent++;
      listing_bytes.delete();
   endtask

   // Holds the sender back until every predicted result has been transferred.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_due != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Result side: before each transfer the receiver stalls for a drawn number of
   // cycles, whether or not a result is waiting, so stalls land on every phase.
   initial begin
      int unsigned hold;
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int lines;
      int reach;
      int level;
      bit is_file;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A file at the root, with the listing ending on a name byte, not a newline.
      add_name(3, 1'b1);
      send_listing();

      // A listing that is nothing but its closing newline has no file at all.
      append_byte(lipl_pkg::CH_NEWLINE);
      send_listing();

      // Directory and a file under it; the final newline must not close an extra line.
      add_name(3, 1'b0);
      append_byte(lipl_pkg::CH_NEWLINE);
      add_tabs(1);
      add_name(3, 1'b1);
      append_byte(lipl_pkg::CH_NEWLINE);
      send_listing();

      // An empty line is a directory of length zero and overwrites the slot at depth
      // one. The listing ends on a tab, which closes an empty directory line.
      add_name(1, 1'b0);
      append_byte(lipl_pkg::CH_NEWLINE);
      append_byte(lipl_pkg::CH_NEWLINE);
      add_tabs(1);
      append_byte(lipl_pkg::CH_DOT);
      append_byte(lipl_pkg::CH_NEWLINE);
      add_tabs(1);
      send_listing();

      // Extreme byte values, a tab in the middle of a name, and a final dot.
      append_byte(8'h00);
      append_byte(8'hFF);
      add_tabs(1);
      append_byte(8'h80);
      append_byte(lipl_pkg::CH_DOT);
      send_listing();

      // More tabs than the store has levels: depth saturates and overflow is raised.
      // That directory sits at the deepest level and must not write any slot, so the
      // file at the root that follows still sees an empty prefix.
      add_tabs(lipl_pkg::MAX_DEPTH + 1);
      add_name(2, 1'b0);
      append_byte(lipl_pkg::CH_NEWLINE);
      add_name(2, 1'b1);
      send_listing();

      // Let the result side empty out completely before the random part starts.
      wait_drained();

      // Random part. Most listings are short trees with short random names, where a
      // line may go at most one level below the last directory. The rest are short
      // runs of raw bytes rich in tabs, newlines and dots.
      bytes_sent    = 0;
      listings_sent = 0;
      while (bytes_sent < 120) begin
         steady = (listings_sent >= 3 && listings_sent < 6);
         if ($urandom_range(0, 9) == 0) wait_drained();
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 12)) begin
               case ($urandom_range(0, 3))
                  0: append_byte(lipl_pkg::CH_TAB);
                  1: append_byte(lipl_pkg::CH_NEWLINE);
                  2: append_byte(lipl_pkg::CH_DOT);
                  default: append_byte(lipl_pkg::CHAR_W'($urandom_range(0, 255)));
               endcase
            end
         end else begin
            lines = $urandom_range(1, 3);
            reach = 0;
            for (int ln = 0; ln < lines; ln++) begin
               level   = $urandom_range(0, reach);
               is_file = ($urandom_range(0, 2) == 0);
               add_tabs(level);
               if (is_file) add_name($urandom_range(1, 4), 1'b1);
               else add_name($urandom_range(0, 4), 1'b0);
               reach = is_file ? level : level + 1;
               if (ln != lines - 1 || $urandom_range(0, 1) == 1)
                  append_byte(lipl_pkg::CH_NEWLINE);
            end
            // A lone empty root directory without a newline would send nothing.
            if (listing_bytes.size() == 0) append_byte(lipl_pkg::CH_NEWLINE);
         end
         send_listing();
      end
      steady = 1'b0;

      // Wait for the last results, then a few cycles more to catch any stray transfer.
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog: the slowest correct run needs well under a fifth of this.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/lipl_pkg.sv
rtl/lipl_ram.sv
rtl/lipl_scan.sv
rtl/lipl_close.sv
rtl/lipl_outq.sv
rtl/longest_indented_path_length_unit.sv
test/lipl_path_checker.sv
test/tb_longest_indented_path_length_unit.sv
